/* hw/rtl/psta_pkg.sv */
// shared types, constants and codes for the projectile speed target adapter
`timescale 1ns / 1ps

package psta_pkg;

   // field widths
   localparam int SPEED_W   = 12;
   localparam int RATE_W    = 8;
   localparam int TARGET_W  = 22;
   localparam int ACTION_W  = 3;
   localparam int RUN_W     = 16;
   localparam int BAND_W    = 8;
   localparam int PROD_W    = SPEED_W + TARGET_W;
   localparam int QUO_W     = TARGET_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 22;

   // defaults for the top-level parameters
   localparam int LOW_RUN_NEEDED_DEF  = 2;
   localparam int HIGH_RUN_NEEDED_DEF = 2;
   localparam int START_TARGET_DEF    = 9050;

   localparam logic [TARGET_W-1:0] ONE_RPM = TARGET_W'(256);

   // action codes
   localparam logic [ACTION_W-1:0] ACT_IDLE      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_SHIELDED  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_WINDOW    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_OVERSPEED = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_RAISED    = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_LOWERED   = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_COUNTING  = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SHIELD     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IDEAL_MIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IDEAL_MAX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_BAND  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OVER_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OVER_STEP  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_STEP   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_STEP  = 3'd7;

   typedef struct packed {
      logic [SPEED_W-1:0] shot_speed;
      logic [RATE_W-1:0]  fire_rate;
   } req_type;

   typedef struct packed {
      logic [TARGET_W-1:0] wheel_target;
      logic [ACTION_W-1:0] action;
   } rsp_type;

   typedef struct packed {
      logic [RUN_W-1:0]    shield_reports;
      logic [SPEED_W-1:0]  ideal_min;
      logic [SPEED_W-1:0]  ideal_max;
      logic [BAND_W-1:0]   dead_band;
      logic [SPEED_W-1:0]  overspeed_limit;
      logic [TARGET_W-1:0] overspeed_step;
      logic [TARGET_W-1:0] low_step;
      logic [TARGET_W-1:0] high_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      shield_reports:  RUN_W'(50),
      ideal_min:       SPEED_W'(2460),
      ideal_max:       SPEED_W'(2480),
      dead_band:       BAND_W'(1),
      overspeed_limit: SPEED_W'(2500),
      overspeed_step:  TARGET_W'(20480),
      low_step:        TARGET_W'(3840),
      high_step:       TARGET_W'(256)
   };

endpackage

/* hw/rtl/psta_cfg.sv */
// configuration register file of the projectile speed target adapter
`timescale 1ns / 1ps

module psta_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [psta_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [psta_pkg::CSR_DAT_W-1:0]      csr_data,
   output psta_pkg::cfg_type                   cfg
);
   import psta_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_SHIELD:     cfg_in.shield_reports  = csr_data[RUN_W-1:0];
            REG_IDEAL_MIN:  cfg_in.ideal_min       = csr_data[SPEED_W-1:0];
            REG_IDEAL_MAX:  cfg_in.ideal_max       = csr_data[SPEED_W-1:0];
            REG_DEAD_BAND:  cfg_in.dead_band       = csr_data[BAND_W-1:0];
            REG_OVER_LIMIT: cfg_in.overspeed_limit = csr_data[SPEED_W-1:0];
            REG_OVER_STEP:  cfg_in.overspeed_step  = csr_data[TARGET_W-1:0];
            REG_LOW_STEP:   cfg_in.low_step        = csr_data[TARGET_W-1:0];
            REG_HIGH_STEP:  cfg_in.high_step       = csr_data[TARGET_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hw/rtl/psta_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module psta_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [psta_pkg::PROD_W-1:0]        dividend,
   input  logic [psta_pkg::SPEED_W-1:0]       divisor,
   output logic                               done,
   output logic [psta_pkg::QUO_W-1:0]         quotient
);
   import psta_pkg::*;

   localparam logic [4:0] CNT_LAST = 5'(QUO_W - 1);

   // caller guarantees dividend[PROD_W-1:QUO_W] < divisor
   logic [SPEED_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SPEED_W:0]   trial;
   logic [SPEED_W:0]   diff;

   assign trial    = {rem_ff, quo_ff[QUO_W-1]};
   assign diff     = trial - {1'b0, divisor};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[PROD_W-1:QUO_W];
         quo_in  = dividend[QUO_W-1:0];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[SPEED_W]) begin
            rem_in = diff[SPEED_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[SPEED_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

/* hw/rtl/projectile_speed_target_adapt.sv */
// top level: projectile speed target adapter with sequencer and divider
// most reports go from the request register through S_EVAL and S_OUT to the response register
// a scaled high-run decrease goes through the divider: 22 iterations, in S_LOAD and S_DIV
// one report in flight: a new request is taken only after S_OUT, which response stalls hold
// reset (synchronous) restores register defaults, clears counters, target to start
`timescale 1ns / 1ps

module projectile_speed_target_adapt #(
   parameter int LOW_RUN_NEEDED  = psta_pkg::LOW_RUN_NEEDED_DEF,
   parameter int HIGH_RUN_NEEDED = psta_pkg::HIGH_RUN_NEEDED_DEF,
   parameter int START_TARGET    = psta_pkg::START_TARGET_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  psta_pkg::req_type               req_data,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output psta_pkg::rsp_type               rsp_data,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [psta_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psta_pkg::CSR_DAT_W-1:0]  csr_data
);
   import psta_pkg::*;

   localparam logic [RUN_W-1:0]    LOW_NEED     = RUN_W'(LOW_RUN_NEEDED);
   localparam logic [RUN_W-1:0]    HIGH_NEED    = RUN_W'(HIGH_RUN_NEEDED);
   localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(START_TARGET * 256);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
   localparam logic [2:0] S_EVAL = 3'd1;  // classify report, update counters
   localparam logic [2:0] S_LOAD = 3'd2;  // multiply and load divider
   localparam logic [2:0] S_DIV  = 3'd3;  // wait for quotient
   localparam logic [2:0] S_OUT  = 3'd4;  // hand result to response register

   cfg_type cfg;

   logic [2:0]          state_ff, state_in;
   req_type             req_ff, req_in;
   logic [RUN_W-1:0]    shield_ff, shield_in;
   logic [RUN_W-1:0]    low_run_ff, low_run_in;
   logic [RUN_W-1:0]    high_run_ff, high_run_in;
   logic [TARGET_W-1:0] target_ff, target_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [SPEED_W-1:0]  excess_ff, excess_in;
   logic [TARGET_W-1:0] step_ff, step_in;
   logic [SPEED_W-1:0]  divisor_ff, divisor_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // datapath helpers
   logic [SPEED_W:0]    speed_lo_side;   // speed + dead band
   logic [SPEED_W:0]    win_hi;          // ideal max + dead band
   logic [RUN_W-1:0]    shield_next;
   logic [RUN_W-1:0]    low_inc;
   logic [RUN_W-1:0]    high_base;
   logic [RUN_W-1:0]    high_inc;
   logic [TARGET_W-1:0] low_amt;
   logic [TARGET_W:0]   up_sum;
   logic [PROD_W-1:0]   product;
   logic                div_done;
   logic [QUO_W-1:0]    quotient;
   logic                req_xfer;
   logic                rsp_free;
   logic                low_hit;

   psta_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // one 12x22 multiply, registered inside the divider on load
   assign product = PROD_W'(excess_ff) * PROD_W'(step_ff);

   psta_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_LOAD),
      .dividend (product),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // report classification terms
   assign speed_lo_side = {1'b0, req_ff.shot_speed} + (SPEED_W+1)'(cfg.dead_band);
   assign win_hi        = {1'b0, cfg.ideal_max} + (SPEED_W+1)'(cfg.dead_band);
   assign shield_next   = shield_ff + RUN_W'(1);
   assign low_hit       = req_ff.shot_speed < cfg.ideal_min;
   assign low_inc       = low_run_ff + RUN_W'(1);
   // a low report clears the high run before the high check
   assign high_base     = low_hit ? '0 : high_run_ff;
   assign high_inc      = high_base + RUN_W'(1);
   assign low_amt       = (cfg.low_step < ONE_RPM) ? ONE_RPM : cfg.low_step;
   assign up_sum        = {1'b0, target_ff} + {1'b0, low_amt};

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      shield_in    = shield_ff;
      low_run_in   = low_run_ff;
      high_run_in  = high_run_ff;
      target_in    = target_ff;
      action_in    = action_ff;
      excess_in    = excess_ff;
      step_in      = step_ff;
      divisor_in   = divisor_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               req_in   = req_data;
               state_in = S_EVAL;
            end
         end

         S_EVAL: begin
            state_in = S_OUT;
            if (req_ff.fire_rate == '0) begin
               // not firing: runs clear, shield count kept
               low_run_in  = '0;
               high_run_in = '0;
               action_in   = ACT_IDLE;
            end else if (shield_next < cfg.shield_reports) begin
               shield_in   = shield_next;
               low_run_in  = '0;
               high_run_in = '0;
               action_in   = ACT_SHIELDED;
            end else begin
               shield_in = '0;
               if (speed_lo_side >= {1'b0, cfg.ideal_min} &&
                   {1'b0, req_ff.shot_speed} <= win_hi) begin
                  low_run_in  = '0;
                  high_run_in = '0;
                  action_in   = ACT_WINDOW;
               end else if (req_ff.shot_speed >= cfg.overspeed_limit) begin
                  target_in   = (cfg.overspeed_step >= target_ff) ? '0
                              : target_ff - cfg.overspeed_step;
                  low_run_in  = '0;
                  high_run_in = '0;
                  action_in   = ACT_OVERSPEED;
               end else if (low_hit && low_inc >= LOW_NEED) begin
                  // low run complete: raise with saturation
                  low_run_in  = '0;
                  high_run_in = '0;
                  target_in   = up_sum[TARGET_W] ? '1 : up_sum[TARGET_W-1:0];
                  action_in   = ACT_RAISED;
               end else if (req_ff.shot_speed > cfg.ideal_max) begin
                  low_run_in = '0;
                  action_in  = ACT_COUNTING;
                  if (high_inc >= HIGH_NEED) begin
                     // high run complete: scaled decrease through the divider
                     high_run_in = '0;
                     action_in   = ACT_LOWERED;
                     excess_in   = req_ff.shot_speed - cfg.ideal_max;
                     step_in     = (cfg.high_step < ONE_RPM) ? ONE_RPM : cfg.high_step;
                     divisor_in  = (cfg.overspeed_limit > cfg.ideal_max)
                                 ? cfg.overspeed_limit - cfg.ideal_max
                                 : SPEED_W'(1);
                     state_in    = S_LOAD;
                  end else begin
                     high_run_in = high_inc;
                  end
               end else begin
                  // low report short of a full run
                  low_run_in  = low_hit ? low_inc : low_run_ff;
                  high_run_in = high_base;
                  action_in   = ACT_COUNTING;
               end
            end
         end

         S_LOAD: begin
            state_in = S_DIV;
         end

         S_DIV: begin
            if (div_done) begin
               target_in = (quotient >= target_ff) ? '0 : target_ff - quotient;
               state_in  = S_OUT;
            end
         end

         S_OUT: begin
            if (rsp_free) begin
               rsp_in.wheel_target = target_ff;
               rsp_in.action       = action_ff;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         shield_ff    <= '0;
         low_run_ff   <= '0;
         high_run_ff  <= '0;
         target_ff    <= TARGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shield_ff    <= shield_in;
         low_run_ff   <= low_run_in;
         high_run_ff  <= high_run_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      action_ff  <= action_in;
      excess_ff  <= excess_in;
      step_ff    <= step_in;
      divisor_ff <= divisor_in;
      rsp_ff     <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   // quotient only arrives while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide wait");

   // a loaded divide is always followed by the wait state
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOAD |=> state_ff == S_DIV)
      else $error("divide load not followed by wait");

   // an accepted request is evaluated in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == S_EVAL)
      else $error("accepted request not evaluated");

   // a new response only comes from the hand-off state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside hand-off");
`endif

endmodule

/* test/tb_top.sv */
// testbench for the projectile speed target adapter: directed script plus random reports
`timescale 1ns / 1ps

module tb_top;
   import psta_pkg::*;

   localparam logic [TARGET_W-1:0] TARGET_TOP   = 22'h3FFFFF;
   localparam logic [TARGET_W-1:0] TARGET_START = TARGET_W'(START_TARGET_DEF * 256);
   localparam int PHASES_PER_MODE = 4;
   localparam int REPORTS_PER_PHASE = 162;
   localparam int HOLD_CYCLES = 120;
   localparam int SETTLE_CYCLES = 40;

   // one line of the directed script; load_set < 0 keeps the current settings
   typedef struct {
      int      load_set;
      req_type req;
      bit      typed;
      rsp_type want;
   } script_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   // shadow copy of the adapter: settings and running state
   cfg_type             settings_now = CFG_RESET;
   logic [RUN_W-1:0]    shield_tally = '0;
   logic [RUN_W-1:0]    low_streak = '0;
   logic [RUN_W-1:0]    high_streak = '0;
   logic [TARGET_W-1:0] target_now = TARGET_START;

   rsp_type        expected_reports[$];
   script_row_type directed_script[$];
   cfg_type        directed_sets[$];

   int mismatch_count = 0;
   int send_idle_pct = 14;
   int recv_idle_pct = 84;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;

   projectile_speed_target_adapt dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // generous fixed bound, several times the slowest legal run
   initial begin
      #(12_000_000);
      $display("FAIL");
      $finish;
   end

   // lower the target, floored at zero
   function automatic void target_drop(longint unsigned amount);
      if (amount >= 64'(target_now))
         target_now = '0;
      else
         target_now = target_now - TARGET_W'(amount);
   endfunction

   // next result of the adapter for one report, advancing the shadow state
   function automatic rsp_type predict_report(req_type r);
      rsp_type res;
      int speed, lo, hi, db, lim, span_div;
      longint unsigned step, sum;
      logic [ACTION_W-1:0] act;
      speed = r.shot_speed;
      lo    = settings_now.ideal_min;
      hi    = settings_now.ideal_max;
      db    = settings_now.dead_band;
      lim   = settings_now.overspeed_limit;
      if (r.fire_rate == '0) begin
         // not firing: runs clear, shield tally is kept
         low_streak  = '0;
         high_streak = '0;
         act = ACT_IDLE;
      end else begin
         shield_tally = shield_tally + 1'b1;
         if (shield_tally < settings_now.shield_reports) begin
            low_streak  = '0;
            high_streak = '0;
            act = ACT_SHIELDED;
         end else begin
            shield_tally = '0;
            act = ACT_COUNTING;
            // window edges may leave the 12-bit range, so compare as signed ints
            if (speed >= lo - db && speed <= hi + db) begin
               low_streak  = '0;
               high_streak = '0;
               act = ACT_WINDOW;
            end else if (speed >= lim) begin
               target_drop(64'(settings_now.overspeed_step));
               low_streak  = '0;
               high_streak = '0;
               act = ACT_OVERSPEED;
            end else begin
               if (speed < lo) begin
                  low_streak  = low_streak + 1'b1;
                  high_streak = '0;
                  if (int'(low_streak) >= LOW_RUN_NEEDED_DEF) begin
                     low_streak = '0;
                     step = (settings_now.low_step < ONE_RPM) ? 64'(ONE_RPM)
                                                              : 64'(settings_now.low_step);
                     sum = 64'(target_now) + step;
                     target_now = (sum > 64'(TARGET_TOP)) ? TARGET_TOP : TARGET_W'(sum);
                     act = ACT_RAISED;
                  end
               end
               // a low report that raised nothing may still count as high
               if (act != ACT_RAISED && speed > hi && speed < lim) begin
                  high_streak = high_streak + 1'b1;
                  low_streak  = '0;
                  if (int'(high_streak) >= HIGH_RUN_NEEDED_DEF) begin
                     high_streak = '0;
                     span_div = lim - hi;
                     if (span_div <= 0)
                        span_div = 1;
                     step = (settings_now.high_step < ONE_RPM) ? 64'(ONE_RPM)
                                                               : 64'(settings_now.high_step);
                     target_drop((64'(speed - hi) * step) / 64'(span_div));
                     act = ACT_LOWERED;
                  end
               end
            end
         end
      end
      res.wheel_target = target_now;
      res.action = act;
      return res;
   endfunction

   function automatic cfg_type make_settings(int shield, int lo, int hi, int db, int lim,
                                             int over_step, int low_step, int high_step);
      cfg_type c;
      c.shield_reports  = RUN_W'(shield);
      c.ideal_min       = SPEED_W'(lo);
      c.ideal_max       = SPEED_W'(hi);
      c.dead_band       = BAND_W'(db);
      c.overspeed_limit = SPEED_W'(lim);
      c.overspeed_step  = TARGET_W'(over_step);
      c.low_step        = TARGET_W'(low_step);
      c.high_step       = TARGET_W'(high_step);
      return c;
   endfunction

   function automatic void add_row(int load_set, int speed, int rate, bit typed = 1'b0,
                                   int tgt = 0, logic [ACTION_W-1:0] act = ACT_IDLE);
      script_row_type row;
      row.load_set = load_set;
      row.req.shot_speed = SPEED_W'(speed);
      row.req.fire_rate = RATE_W'(rate);
      row.typed = typed;
      row.want.wheel_target = TARGET_W'(tgt);
      row.want.action = act;
      directed_script.push_back(row);
   endfunction

   function automatic int clamp_speed(int s);
      if (s < 0)
         return 0;
      if (s > 4095)
         return 4095;
      return s;
   endfunction

   // mostly a narrow window at a random place, now and then odd or inverted
   function automatic cfg_type random_settings();
      int shield, lo, hi, db, lim, over_step, low_step, high_step, pick;
      pick = $urandom_range(19);
      shield = (pick == 0) ? 0 : (pick == 1) ? 65535 : (pick < 4) ? $urandom_range(2, 8) : 1;
      lo = $urandom_range(4095);
      hi = clamp_speed(lo + $urandom_range(200));
      if ($urandom_range(9) == 0)
         hi = $urandom_range(4095);
      db = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(4);
      lim = ($urandom_range(4) == 0) ? $urandom_range(4095)
                                     : clamp_speed(hi + $urandom_range(1, 400));
      over_step = ($urandom_range(4) == 0) ? $urandom_range(4194303) : $urandom_range(65535);
      pick = $urandom_range(9);
      low_step = (pick == 0) ? $urandom_range(255)
               : (pick < 3) ? $urandom_range(4194303) : $urandom_range(256, 20000);
      pick = $urandom_range(9);
      high_step = (pick == 0) ? $urandom_range(255)
                : (pick < 3) ? $urandom_range(4194303) : $urandom_range(256, 20000);
      return make_settings(shield, lo, hi, db, lim, over_step, low_step, high_step);
   endfunction

   // speed drawn from a zone around the current window so that runs build up
   function automatic req_type random_report(int zone);
      req_type r;
      int lo, hi, db, lim, span, s, pick;
      lo  = settings_now.ideal_min;
      hi  = settings_now.ideal_max;
      db  = settings_now.dead_band;
      lim = settings_now.overspeed_limit;
      case (zone) inside
         [0:1]: s = $urandom_range(4095);
         [2:6]: begin
            span = hi + db - (lo - db) + 4;
            s = lo - db - 2 + ((span > 0) ? $urandom_range(span) : 0);
         end
         [7:11]: s = hi + 1 + ((lim - hi - 2 > 0) ? $urandom_range(lim - hi - 2) : 0);
         [12:15]: s = lo - 1 - $urandom_range((lo < 300) ? lo : 300);
         [16:17]: s = lim + ((lim < 4095) ? $urandom_range(4095 - lim) : 0);
         default: s = $urandom_range(1) * 4095;
      endcase
      r.shot_speed = SPEED_W'(clamp_speed(s));
      pick = $urandom_range(19);
      r.fire_rate = (pick == 0) ? '0 : (pick == 1) ? 8'hFF : RATE_W'($urandom_range(1, 254));
      return r;
   endfunction

   task automatic wait_drained(int settle);
      do @(posedge clock); while (expected_reports.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // one register write; csr_valid stays up for a following write
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] value,
                            int width, bit junk);
      logic [CSR_DAT_W-1:0] noise;
      noise = junk ? (CSR_DAT_W'($urandom) & ~((CSR_DAT_W'(1) << width) - 1'b1)) : '0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value | noise;
      do @(posedge clock); while (!csr_ready);
   endtask

   // writes every register, with stray bits above the field when junk is set
   task automatic load_settings(cfg_type c, bit junk);
      write_reg(REG_SHIELD,     CSR_DAT_W'(c.shield_reports),  RUN_W,    junk);
      write_reg(REG_IDEAL_MIN,  CSR_DAT_W'(c.ideal_min),       SPEED_W,  junk);
      write_reg(REG_IDEAL_MAX,  CSR_DAT_W'(c.ideal_max),       SPEED_W,  junk);
      write_reg(REG_DEAD_BAND,  CSR_DAT_W'(c.dead_band),       BAND_W,   junk);
      write_reg(REG_OVER_LIMIT, CSR_DAT_W'(c.overspeed_limit), SPEED_W,  junk);
      write_reg(REG_OVER_STEP,  CSR_DAT_W'(c.overspeed_step),  TARGET_W, junk);
      write_reg(REG_LOW_STEP,   CSR_DAT_W'(c.low_step),        TARGET_W, junk);
      write_reg(REG_HIGH_STEP,  CSR_DAT_W'(c.high_step),       TARGET_W, junk);
      csr_valid <= 1'b0;
      settings_now = c;
   endtask

   // offer one report after a random idle gap; the expectation is queued at its transfer
   task automatic offer(req_type r, bit typed, rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predicted = predict_report(r);
      expected_reports.push_back(typed ? want : predicted);
   endtask

   // response side: check each transfer, then pick the stall for the next cycle
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("response with no report waiting: wheel_target %0d action %0d",
                      rsp_data.wheel_target, rsp_data.action);
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_data.wheel_target !== want.wheel_target) begin
                  $error("wheel_target: expected %0d, actual %0d",
                         want.wheel_target, rsp_data.wheel_target);
                  mismatch_count++;
               end
               if (rsp_data.action !== want.action) begin
                  $error("action: expected %0d, actual %0d", want.action, rsp_data.action);
                  mismatch_count++;
               end
            end
         end
         // long hold-off on request, so the adapter fills up and stalls its input
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      int mode, phase, n, zone;
      rsp_type none;
      none = '0;

      // directed settings, referenced by index from the script
      // 0: every report evaluated, default window
      directed_sets.push_back(make_settings(1, 2460, 2480, 1, 2500, 20480, 3840, 256));
      // 1: window swallows every speed, lower edge goes negative
      directed_sets.push_back(make_settings(0, 0, 4095, 255, 4095, 0, 256, 256));
      // 2: inverted window, huge overspeed step, steps below one rpm
      directed_sets.push_back(make_settings(1, 4095, 0, 0, 4095, 4194303, 0, 0));
      // 3: zero steps, low and high runs clamp to one rpm
      directed_sets.push_back(make_settings(1, 2000, 2100, 0, 3000, 0, 0, 0));
      // 4: full-scale steps, raise saturates at the top
      directed_sets.push_back(make_settings(1, 4000, 4095, 0, 4095, 0, 4194303, 4194303));

      // reset defaults: masked while firing
      add_row(-1,    0,   0, 1'b1, TARGET_START, ACT_IDLE);
      add_row(-1, 4095, 255, 1'b1, TARGET_START, ACT_SHIELDED);
      add_row(-1, 2470,   1, 1'b1, TARGET_START, ACT_SHIELDED);
      // every report evaluated: window, overspeed, low run, high run, window edges
      add_row( 0, 2470,   7, 1'b1, TARGET_START, ACT_WINDOW);
      add_row(-1, 4095, 255, 1'b1, TARGET_START - 20480, ACT_OVERSPEED);
      add_row(-1,    0,   1);
      add_row(-1, 2458,   3);
      add_row(-1, 2482,   9);
      add_row(-1, 2499, 200);
      add_row(-1, 2459,  64);
      add_row(-1, 2481, 128);
      add_row(-1, 2500,   2);
      add_row(-1,    0,   0);
      add_row( 1, 4095, 128);
      add_row(-1,    0,  85);
      add_row( 2, 4095,   1, 1'b1, 0, ACT_OVERSPEED);
      add_row(-1,  100,   1);
      add_row(-1,  100,   1);
      add_row( 3, 1000,  17);
      add_row(-1, 1000,  34);
      add_row(-1, 2999,  68);
      add_row(-1, 2999, 136);
      add_row(-1, 3000, 255);
      add_row( 4,    0, 170);
      add_row(-1,    0,  51);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_script[i]) begin
         if (directed_script[i].load_set >= 0) begin
            req_valid <= 1'b0;
            wait_drained(SETTLE_CYCLES);
            load_settings(directed_sets[directed_script[i].load_set], 1'b1);
         end
         offer(directed_script[i].req, directed_script[i].typed, directed_script[i].want);
      end

      // random part: three idling patterns, several settings in each
      zone = 0;
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 14; recv_idle_pct = 84; end
            1: begin send_idle_pct = 84; recv_idle_pct = 14; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (phase = 0; phase < PHASES_PER_MODE; phase++) begin
            req_valid <= 1'b0;
            wait_drained(SETTLE_CYCLES);
            load_settings(random_settings(), $urandom_range(1));
            for (n = 0; n < REPORTS_PER_PHASE; n++) begin
               if (n == 40 && phase == 0 && mode != 1)
                  hold_asked <= hold_asked + 1;
               // sender stops until the adapter has answered everything
               if (n == 80 && phase == mode) begin
                  req_valid <= 1'b0;
                  wait_drained(0);
               end
               // keep a zone for a few reports so low and high runs complete
               if ($urandom_range(99) < 40)
                  zone = $urandom_range(19);
               offer(random_report(zone), 1'b0, none);
            end
         end
      end

      req_valid <= 1'b0;
      wait_drained(SETTLE_CYCLES);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/psta_pkg.sv
hw/rtl/psta_cfg.sv
hw/rtl/psta_div.sv
hw/rtl/projectile_speed_target_adapt.sv
test/tb_top.sv
